>>> sv/vsa_pkg.sv
// Shared types and constants of the voice slot allocator.
`timescale 1ns / 1ps
package vsa_pkg;

    localparam int NUM_GROUPS = 3;
    localparam int LIM_W      = 8;
    localparam int PRIO_W     = 13;
    localparam int SUM_W      = 14;
    localparam int AGE_W      = 32;
    localparam int SLOT_W     = 7;
    localparam int CFG_IDX_W  = 3;

    typedef logic [1:0] t_grp;
    localparam t_grp GRP_WPN = 2'd0;
    localparam t_grp GRP_VEH = 2'd1;
    localparam t_grp GRP_RT  = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_REFUSED = 2'd1;
    localparam t_status ST_EMPTY   = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WPN_LIM  = 3'd0;
    localparam t_cfg_idx CFG_VEH_LIM  = 3'd1;
    localparam t_cfg_idx CFG_RT_LIM   = 3'd2;
    localparam t_cfg_idx CFG_PHYS_LIM = 3'd3;
    localparam t_cfg_idx CFG_RESV     = 3'd4;

    localparam logic [LIM_W-1:0] RST_WPN_LIM  = 8'd48;
    localparam logic [LIM_W-1:0] RST_VEH_LIM  = 8'd40;
    localparam logic [LIM_W-1:0] RST_RT_LIM   = 8'd48;
    localparam logic [LIM_W-1:0] RST_PHYS_LIM = 8'd96;
    localparam logic [LIM_W-1:0] RST_RESV     = 8'd12;

    localparam logic signed [SUM_W-1:0] DB_FRONT  = SUM_W'(24 * 16);
    localparam logic signed [SUM_W-1:0] DB_LOOP   = SUM_W'(6 * 16);
    localparam logic signed [SUM_W-1:0] DB_REPORT = SUM_W'(10 * 16);
    localparam logic signed [SUM_W-1:0] DB_BULLET = SUM_W'(3 * 16);
    localparam logic signed [SUM_W-1:0] DB_TAIL   = SUM_W'(2 * 16);
    localparam logic signed [SUM_W-1:0] SAT_LO    = SUM_W'(-4096);
    localparam logic signed [SUM_W-1:0] SAT_HI    = SUM_W'(4095);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_FIN
    } t_state;

    typedef struct packed {
        t_grp                     grp;
        logic signed [PRIO_W-1:0] prio;
        logic [AGE_W-1:0]         age;
    } t_entry;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } t_tbl_cmd;

    typedef struct packed {
        logic start;
        logic step;
    } t_scan_cmd;

endpackage

>>> sv/vsa_prio.sv
// Priority derivation of a new voice with saturation to the table range.
`timescale 1ns / 1ps
module vsa_prio (
    input  logic signed [11:0]                  i_mix_level,
    input  logic signed [11:0]                  i_output_gain,
    input  logic                                i_front_end,
    input  logic                                i_looping,
    input  logic                                i_loop_pending,
    input  logic                                i_reports_completion,
    input  logic                                i_bullet_hit,
    input  logic                                i_tail,
    output logic signed [vsa_pkg::PRIO_W-1:0]   o_prio
);

    logic signed [vsa_pkg::SUM_W-1:0] w_sum;

    always_comb begin
        w_sum = vsa_pkg::SUM_W'(i_mix_level) + vsa_pkg::SUM_W'(i_output_gain);
        if (i_front_end) begin
            w_sum = w_sum + vsa_pkg::DB_FRONT;
        end
        if (i_looping || i_loop_pending) begin
            w_sum = w_sum + vsa_pkg::DB_LOOP;
        end
        if (i_reports_completion) begin
            w_sum = w_sum + vsa_pkg::DB_REPORT;
        end
        if (i_bullet_hit) begin
            w_sum = w_sum - vsa_pkg::DB_BULLET;
        end
        if (i_tail) begin
            w_sum = w_sum - vsa_pkg::DB_TAIL;
        end
        if (w_sum < vsa_pkg::SAT_LO) begin
            w_sum = vsa_pkg::SAT_LO;
        end else if (w_sum > vsa_pkg::SAT_HI) begin
            w_sum = vsa_pkg::SAT_HI;
        end
        o_prio = w_sum[vsa_pkg::PRIO_W-1:0];
    end

endmodule

>>> sv/vsa_table.sv
// Voice table: entry memory with registered read and per-slot valid bits.
`timescale 1ns / 1ps
module vsa_table #(
    parameter int MAX_VOICES = 128,
    parameter int IDX_W      = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vsa_pkg::t_tbl_cmd     i_cmd,
    input  logic [IDX_W-1:0]      i_rd_addr,
    input  logic [IDX_W-1:0]      i_wr_addr,
    input  vsa_pkg::t_entry       i_wr_entry,
    input  logic [IDX_W-1:0]      i_clr_addr,
    output logic                  o_rd_vld,
    output logic [IDX_W-1:0]      o_rd_idx,
    output logic                  o_rd_valid_bit,
    output vsa_pkg::t_entry       o_rd_entry
);

    vsa_pkg::t_entry         r_mem [MAX_VOICES];
    logic [MAX_VOICES-1:0]   r_valid;
    logic [MAX_VOICES-1:0]   n_valid;
    logic                    r_rd_vld;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_rd_valid_bit;
    vsa_pkg::t_entry         r_rd_entry;

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.clr_en) begin
            n_valid[i_clr_addr] = 1'b0;
        end
        if (i_cmd.wr_en) begin
            n_valid[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_cmd.rd_en) begin
            r_rd_entry     <= r_mem[i_rd_addr];
            r_rd_idx       <= i_rd_addr;
            r_rd_valid_bit <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_vld       = r_rd_vld;
    assign o_rd_idx       = r_rd_idx;
    assign o_rd_valid_bit = r_rd_valid_bit;
    assign o_rd_entry     = r_rd_entry;

endmodule

>>> sv/vsa_scan.sv
// Shared compare unit: tracks the lowest free slot and the best victim over a scan.
`timescale 1ns / 1ps
module vsa_scan #(
    parameter int IDX_W = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vsa_pkg::t_scan_cmd                  i_cmd,
    input  logic [vsa_pkg::NUM_GROUPS-1:0]      i_elig,
    input  logic [vsa_pkg::AGE_W-1:0]           i_age_now,
    input  logic [IDX_W-1:0]                    i_rd_idx,
    input  logic                                i_rd_valid_bit,
    input  vsa_pkg::t_entry                     i_rd_entry,
    output logic                                o_free_found,
    output logic [IDX_W-1:0]                    o_free_idx,
    output logic                                o_vic_found,
    output logic [IDX_W-1:0]                    o_vic_idx,
    output vsa_pkg::t_grp                       o_vic_grp,
    output logic signed [vsa_pkg::PRIO_W-1:0]   o_vic_prio
);

    logic                              r_free_found;
    logic [IDX_W-1:0]                  r_free_idx;
    logic                              r_vic_found;
    logic [IDX_W-1:0]                  r_vic_idx;
    vsa_pkg::t_grp                     r_vic_grp;
    logic signed [vsa_pkg::PRIO_W-1:0] r_vic_prio;
    logic [vsa_pkg::AGE_W-1:0]         r_vic_diff;

    logic [vsa_pkg::AGE_W-1:0]         w_diff;
    logic                              w_cand;
    logic                              w_better;
    logic                              w_take_vic;
    logic                              w_take_free;

    always_comb begin
        w_diff   = i_age_now - i_rd_entry.age;
        w_cand   = i_rd_valid_bit && (i_rd_entry.grp != 2'd3) && i_elig[i_rd_entry.grp];
        w_better = !r_vic_found || (i_rd_entry.prio < r_vic_prio) ||
                   ((i_rd_entry.prio == r_vic_prio) && (w_diff > r_vic_diff));
        w_take_vic  = i_cmd.step && w_cand && w_better;
        w_take_free = i_cmd.step && !i_rd_valid_bit && !r_free_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end else if (i_cmd.start) begin
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end else begin
            if (w_take_free) begin
                r_free_found <= 1'b1;
            end
            if (w_take_vic) begin
                r_vic_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_free) begin
            r_free_idx <= i_rd_idx;
        end
        if (w_take_vic) begin
            r_vic_idx  <= i_rd_idx;
            r_vic_grp  <= i_rd_entry.grp;
            r_vic_prio <= i_rd_entry.prio;
            r_vic_diff <= w_diff;
        end
    end

    assign o_free_found = r_free_found;
    assign o_free_idx   = r_free_idx;
    assign o_vic_found  = r_vic_found;
    assign o_vic_idx    = r_vic_idx;
    assign o_vic_grp    = r_vic_grp;
    assign o_vic_prio   = r_vic_prio;

endmodule

>>> sv/voice_slot_allocator_with_stealing.sv
// Top level of the voice slot allocator with priority stealing.
//
// Input channel (i_in_valid / o_in_ready) takes one word per request: an
// allocate (i_mode 0) or a release (i_mode 1). Output channel (o_out_valid /
// i_out_ready) returns exactly one result word per request. The config port
// (i_cfg_we, i_cfg_idx, i_cfg_data) writes the group limits, the physical
// limit and the reservation, with no handshake.
// An allocate walks the whole voice table through one memory read port, one
// entry per cycle, while a single compare unit keeps the lowest free slot
// and the best victim. A release reads one entry.
// One request is in flight at a time; o_in_ready is high only while idle.
// The result sits in an output register; a stalled receiver holds it there,
// and the next request may be accepted and worked on meanwhile, but its
// result waits until the register is taken.
// Reset clears the valid bits, the group and total counts, the age counter
// and loads the default limits; it needs no clearing pass.
`timescale 1ns / 1ps
module voice_slot_allocator_with_stealing #(
    parameter int MAX_VOICES = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vsa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [vsa_pkg::LIM_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [6:0]                          i_release_slot,
    input  logic                                i_is_runtime_effect,
    input  logic                                i_has_vehicle_source,
    input  logic signed [11:0]                  i_mix_level,
    input  logic signed [11:0]                  i_output_gain,
    input  logic                                i_front_end,
    input  logic                                i_looping,
    input  logic                                i_loop_pending,
    input  logic                                i_reports_completion,
    input  logic                                i_bullet_hit,
    input  logic                                i_tail,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic [6:0]                          o_slot,
    output logic                                o_evicted,
    output logic [6:0]                          o_evicted_slot,
    output logic signed [vsa_pkg::PRIO_W-1:0]   o_priority_res
);

    localparam int IDX_W = $clog2(MAX_VOICES);
    localparam int CNT_W = $clog2(MAX_VOICES + 1);
    localparam int CMP_W = (CNT_W > vsa_pkg::LIM_W) ? CNT_W : vsa_pkg::LIM_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VOICES - 1);
    localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_VOICES);

    vsa_pkg::t_state                   r_state, n_state;

    logic [vsa_pkg::LIM_W-1:0]         r_lim_wpn, r_lim_veh, r_lim_rt, r_lim_phys, r_resv;
    logic [CNT_W-1:0]                  r_grp_cnt [vsa_pkg::NUM_GROUPS];
    logic [CNT_W-1:0]                  n_grp_cnt [vsa_pkg::NUM_GROUPS];
    logic [CNT_W-1:0]                  r_total, n_total;
    logic [vsa_pkg::AGE_W-1:0]         r_age, n_age;
    logic [IDX_W-1:0]                  r_idx, n_idx;
    logic                              r_out_valid, n_out_valid;

    vsa_pkg::t_grp                     r_grp, n_grp;
    logic signed [vsa_pkg::PRIO_W-1:0] r_prio, n_prio;
    logic                              r_steal, n_steal;
    logic [vsa_pkg::NUM_GROUPS-1:0]    r_elig, n_elig;
    logic [6:0]                        r_rel_slot, n_rel_slot;
    logic                              r_rel_oor, n_rel_oor;

    vsa_pkg::t_status                  r_res_status, n_res_status;
    logic [6:0]                        r_res_slot, n_res_slot;
    logic                              r_res_ev, n_res_ev;
    logic [6:0]                        r_res_evslot, n_res_evslot;
    logic signed [vsa_pkg::PRIO_W-1:0] r_res_prio, n_res_prio;

    vsa_pkg::t_status                  r_out_status, n_out_status;
    logic [6:0]                        r_out_slot, n_out_slot;
    logic                              r_out_ev, n_out_ev;
    logic [6:0]                        r_out_evslot, n_out_evslot;
    logic signed [vsa_pkg::PRIO_W-1:0] r_out_prio, n_out_prio;

    logic                              w_in_acc;
    logic signed [vsa_pkg::PRIO_W-1:0] w_prio;
    vsa_pkg::t_grp                     w_grp;
    logic [vsa_pkg::LIM_W-1:0]         w_lim;
    logic                              w_full;
    logic                              w_phys_full;
    logic [IDX_W-1:0]                  w_new_slot;

    vsa_pkg::t_tbl_cmd                 w_tbl_cmd;
    logic [IDX_W-1:0]                  w_rd_addr;
    logic [IDX_W-1:0]                  w_wr_addr;
    logic [IDX_W-1:0]                  w_clr_addr;
    vsa_pkg::t_entry                   w_wr_entry;
    logic                              w_rd_vld;
    logic [IDX_W-1:0]                  w_rd_idx;
    logic                              w_rd_valid_bit;
    vsa_pkg::t_entry                   w_rd_entry;

    vsa_pkg::t_scan_cmd                w_scan_cmd;
    logic                              w_free_found;
    logic [IDX_W-1:0]                  w_free_idx;
    logic                              w_vic_found;
    logic [IDX_W-1:0]                  w_vic_idx;
    vsa_pkg::t_grp                     w_vic_grp;
    logic signed [vsa_pkg::PRIO_W-1:0] w_vic_prio;

    vsa_prio u_prio (
        .i_mix_level          (i_mix_level),
        .i_output_gain        (i_output_gain),
        .i_front_end          (i_front_end),
        .i_looping            (i_looping),
        .i_loop_pending       (i_loop_pending),
        .i_reports_completion (i_reports_completion),
        .i_bullet_hit         (i_bullet_hit),
        .i_tail               (i_tail),
        .o_prio               (w_prio)
    );

    vsa_table #(
        .MAX_VOICES (MAX_VOICES),
        .IDX_W      (IDX_W)
    ) u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_tbl_cmd),
        .i_rd_addr      (w_rd_addr),
        .i_wr_addr      (w_wr_addr),
        .i_wr_entry     (w_wr_entry),
        .i_clr_addr     (w_clr_addr),
        .o_rd_vld       (w_rd_vld),
        .o_rd_idx       (w_rd_idx),
        .o_rd_valid_bit (w_rd_valid_bit),
        .o_rd_entry     (w_rd_entry)
    );

    vsa_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_scan_cmd),
        .i_elig         (r_elig),
        .i_age_now      (r_age),
        .i_rd_idx       (w_rd_idx),
        .i_rd_valid_bit (w_rd_valid_bit),
        .i_rd_entry     (w_rd_entry),
        .o_free_found   (w_free_found),
        .o_free_idx     (w_free_idx),
        .o_vic_found    (w_vic_found),
        .o_vic_idx      (w_vic_idx),
        .o_vic_grp      (w_vic_grp),
        .o_vic_prio     (w_vic_prio)
    );

    // request decode at accept
    always_comb begin
        w_in_acc = i_in_valid && (r_state == vsa_pkg::S_IDLE);
        if (i_is_runtime_effect) begin
            w_grp = vsa_pkg::GRP_RT;
        end else if (i_has_vehicle_source) begin
            w_grp = vsa_pkg::GRP_VEH;
        end else begin
            w_grp = vsa_pkg::GRP_WPN;
        end
        unique case (w_grp)
            vsa_pkg::GRP_WPN: w_lim = r_lim_wpn;
            vsa_pkg::GRP_VEH: w_lim = r_lim_veh;
            default:          w_lim = r_lim_rt;
        endcase
        w_full      = CMP_W'(r_grp_cnt[w_grp]) >= CMP_W'(w_lim);
        w_phys_full = (CMP_W'(r_total) >= CMP_W'(r_lim_phys)) || (CMP_W'(r_total) >= MAX_CMP);
        for (int k = 0; k < vsa_pkg::NUM_GROUPS; k++) begin
            n_elig[k] = w_full ? (w_grp == 2'(k))
                               : (CMP_W'(r_grp_cnt[k]) > CMP_W'(r_resv));
        end
    end

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_age        = r_age;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_grp        = r_grp;
        n_prio       = r_prio;
        n_steal      = r_steal;
        n_rel_slot   = r_rel_slot;
        n_rel_oor    = r_rel_oor;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_ev     = r_res_ev;
        n_res_evslot = r_res_evslot;
        n_res_prio   = r_res_prio;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_ev     = r_out_ev;
        n_out_evslot = r_out_evslot;
        n_out_prio   = r_out_prio;
        for (int k = 0; k < vsa_pkg::NUM_GROUPS; k++) begin
            n_grp_cnt[k] = r_grp_cnt[k];
        end

        w_tbl_cmd  = '0;
        w_scan_cmd = '0;
        w_rd_addr  = r_idx;
        w_wr_addr  = w_free_idx;
        w_clr_addr = IDX_W'(r_rel_slot);
        w_wr_entry = '{grp: r_grp, prio: r_prio, age: r_age};
        w_new_slot = w_free_idx;

        unique case (r_state)
            vsa_pkg::S_IDLE: begin
                w_rd_addr = IDX_W'(i_release_slot);
                if (w_in_acc) begin
                    n_rel_slot = i_release_slot;
                    n_rel_oor  = 32'(i_release_slot) >= 32'(MAX_VOICES);
                    n_grp      = w_grp;
                    n_prio     = w_prio;
                    n_steal    = w_full || w_phys_full;
                    n_idx      = '0;
                    if (i_mode) begin
                        w_tbl_cmd.rd_en = 1'b1;
                        n_state         = vsa_pkg::S_REL;
                    end else begin
                        w_scan_cmd.start = 1'b1;
                        n_state          = vsa_pkg::S_SCAN;
                    end
                end
            end
            vsa_pkg::S_REL: begin
                n_res_slot   = r_rel_slot;
                n_res_ev     = 1'b0;
                n_res_evslot = '0;
                n_res_prio   = '0;
                if (r_rel_oor || !w_rd_valid_bit) begin
                    n_res_status = vsa_pkg::ST_EMPTY;
                end else begin
                    n_res_status     = vsa_pkg::ST_DONE;
                    w_tbl_cmd.clr_en = 1'b1;
                    n_grp_cnt[w_rd_entry.grp] = r_grp_cnt[w_rd_entry.grp] - CNT_W'(1);
                    n_total          = r_total - CNT_W'(1);
                end
                n_state = vsa_pkg::S_FIN;
            end
            vsa_pkg::S_SCAN: begin
                w_tbl_cmd.rd_en = 1'b1;
                w_scan_cmd.step = w_rd_vld;
                n_idx           = r_idx + IDX_W'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = vsa_pkg::S_DRAIN;
                end
            end
            vsa_pkg::S_DRAIN: begin
                w_scan_cmd.step = w_rd_vld;
                n_state         = vsa_pkg::S_DECIDE;
            end
            vsa_pkg::S_DECIDE: begin
                n_res_prio   = r_prio;
                n_res_status = vsa_pkg::ST_REFUSED;
                n_res_slot   = '0;
                n_res_ev     = 1'b0;
                n_res_evslot = '0;
                if (r_steal) begin
                    if (w_vic_found && (w_vic_prio < r_prio)) begin
                        w_new_slot = (w_free_found && (w_free_idx < w_vic_idx)) ? w_free_idx
                                                                                 : w_vic_idx;
                        w_clr_addr       = w_vic_idx;
                        w_tbl_cmd.clr_en = 1'b1;
                        w_tbl_cmd.wr_en  = 1'b1;
                        n_grp_cnt[w_vic_grp] = n_grp_cnt[w_vic_grp] - CNT_W'(1);
                        n_res_ev     = 1'b1;
                        n_res_evslot = 7'(w_vic_idx);
                    end
                end else if (w_free_found) begin
                    w_new_slot      = w_free_idx;
                    w_tbl_cmd.wr_en = 1'b1;
                    n_total         = r_total + CNT_W'(1);
                end
                if (w_tbl_cmd.wr_en) begin
                    w_wr_addr         = w_new_slot;
                    n_grp_cnt[r_grp]  = n_grp_cnt[r_grp] + CNT_W'(1);
                    n_age             = r_age + 32'd1;
                    n_res_status      = vsa_pkg::ST_DONE;
                    n_res_slot        = 7'(w_new_slot);
                end
                n_state = vsa_pkg::S_FIN;
            end
            vsa_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_ev     = r_res_ev;
                    n_out_evslot = r_res_evslot;
                    n_out_prio   = r_res_prio;
                    n_state      = vsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vsa_pkg::S_IDLE;
            r_lim_wpn   <= vsa_pkg::RST_WPN_LIM;
            r_lim_veh   <= vsa_pkg::RST_VEH_LIM;
            r_lim_rt    <= vsa_pkg::RST_RT_LIM;
            r_lim_phys  <= vsa_pkg::RST_PHYS_LIM;
            r_resv      <= vsa_pkg::RST_RESV;
            r_total     <= '0;
            r_age       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < vsa_pkg::NUM_GROUPS; k++) begin
                r_grp_cnt[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_age       <= n_age;
            r_out_valid <= n_out_valid;
            for (int k = 0; k < vsa_pkg::NUM_GROUPS; k++) begin
                r_grp_cnt[k] <= n_grp_cnt[k];
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vsa_pkg::CFG_WPN_LIM:  r_lim_wpn  <= i_cfg_data;
                    vsa_pkg::CFG_VEH_LIM:  r_lim_veh  <= i_cfg_data;
                    vsa_pkg::CFG_RT_LIM:   r_lim_rt   <= i_cfg_data;
                    vsa_pkg::CFG_PHYS_LIM: r_lim_phys <= i_cfg_data;
                    vsa_pkg::CFG_RESV:     r_resv     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_grp        <= n_grp;
        r_prio       <= n_prio;
        r_steal      <= n_steal;
        r_rel_slot   <= n_rel_slot;
        r_rel_oor    <= n_rel_oor;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_ev     <= n_res_ev;
        r_res_evslot <= n_res_evslot;
        r_res_prio   <= n_res_prio;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_ev     <= n_out_ev;
        r_out_evslot <= n_out_evslot;
        r_out_prio   <= n_out_prio;
        if (w_in_acc) begin
            r_elig <= n_elig;
        end
    end

    assign o_in_ready     = (r_state == vsa_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_evicted      = r_out_ev;
    assign o_evicted_slot = r_out_evslot;
    assign o_priority_res = r_out_prio;

    a_cnt_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W + 2)'(r_grp_cnt[0]) + (CNT_W + 2)'(r_grp_cnt[1]) + (CNT_W + 2)'(r_grp_cnt[2])
            == (CNT_W + 2)'(r_total))
        else $error("group counts do not add up to total");

    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_total) <= MAX_CMP)
        else $error("total voice count above table size");

    a_evict_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted) |-> (o_status == vsa_pkg::ST_DONE))
        else $error("eviction reported on a refused or release word");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held high after accepting a word");

    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vsa_pkg::S_FIN && (!r_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("result word not loaded into output register");

endmodule

>>> sim/voice_table_tb_pkg.sv
// Request and result words of the voice allocator and a tracker that predicts and checks results.
`timescale 1ns / 1ps
package voice_table_tb_pkg;
    import vsa_pkg::*;

    localparam int VOICES     = 128;
    localparam int DB_UNIT    = 16;
    localparam int PRIO_FLOOR = -4096;
    localparam int PRIO_CEIL  = 4095;

    typedef struct {
        bit                 mode;
        bit [SLOT_W-1:0]    rel_slot;
        bit                 is_rt;
        bit                 has_veh;
        logic signed [11:0] mix;
        logic signed [11:0] gain;
        bit                 front_end;
        bit                 looping;
        bit                 loop_pending;
        bit                 reports;
        bit                 bullet;
        bit                 tail;
    } t_voice_req;

    typedef struct {
        t_status                  status;
        logic [SLOT_W-1:0]        slot;
        logic                     evicted;
        logic [SLOT_W-1:0]        ev_slot;
        logic signed [PRIO_W-1:0] prio;
    } t_voice_outcome;

    class voice_table_tracker;
        bit          used [VOICES];
        t_grp        grp_of [VOICES];
        int          prio_of [VOICES];
        bit [31:0]   age_of [VOICES];
        int          grp_cnt [NUM_GROUPS];
        int          total;
        bit [31:0]   age_now;
        int          grp_limit [NUM_GROUPS];
        int          phys_limit;
        int          resv;

        t_voice_outcome awaited_outcomes [$];

        int n_errors;
        int n_checked;
        int n_alloc;
        int n_steal;
        int n_refused;
        int n_release;
        int n_empty;

        function new();
            foreach (used[i]) used[i] = 1'b0;
            foreach (grp_cnt[i]) grp_cnt[i] = 0;
            total = 0;
            age_now = '0;
            grp_limit[GRP_WPN] = 48;
            grp_limit[GRP_VEH] = 40;
            grp_limit[GRP_RT]  = 48;
            phys_limit = 96;
            resv = 12;
            n_errors = 0;
            n_checked = 0;
            n_alloc = 0;
            n_steal = 0;
            n_refused = 0;
            n_release = 0;
            n_empty = 0;
        endfunction

        function void set_limit(t_cfg_idx idx, int value);
            case (idx)
                CFG_WPN_LIM:  grp_limit[GRP_WPN] = value & 8'hFF;
                CFG_VEH_LIM:  grp_limit[GRP_VEH] = value & 8'hFF;
                CFG_RT_LIM:   grp_limit[GRP_RT]  = value & 8'hFF;
                CFG_PHYS_LIM: phys_limit = value & 8'hFF;
                CFG_RESV:     resv = value & 8'hFF;
                default: ;
            endcase
        endfunction

        function int awaited_count();
            return awaited_outcomes.size();
        endfunction

        function int pick_live_slot();
            int live [$];
            int i;
            for (i = 0; i < VOICES; i++) begin
                if (used[i]) live.insert(live.size(), i);
            end
            if (live.size() == 0) return -1;
            return live[$urandom_range(live.size() - 1)];
        endfunction

        function void drop_voice(int s);
            used[s] = 1'b0;
            grp_cnt[grp_of[s]]--;
            total--;
        endfunction

        function t_voice_outcome resolve_request(t_voice_req r);
            t_voice_outcome o;
            t_grp           g;
            int             p;
            int             phys;
            int             victim;
            int             free_slot;
            int             i;
            bit             full;
            bit [31:0]      span_i;
            bit [31:0]      span_v;

            o = '{default: '0};
            if (r.mode) begin
                n_release++;
                o.slot = r.rel_slot;
                if (!used[r.rel_slot]) begin
                    o.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    drop_voice(r.rel_slot);
                    o.status = ST_DONE;
                end
                return o;
            end

            n_alloc++;
            g = r.is_rt ? GRP_RT : (r.has_veh ? GRP_VEH : GRP_WPN);
            p = r.mix;
            p += r.gain;
            if (r.front_end) p += 24 * DB_UNIT;
            if (r.looping || r.loop_pending) p += 6 * DB_UNIT;
            if (r.reports) p += 10 * DB_UNIT;
            if (r.bullet) p -= 3 * DB_UNIT;
            if (r.tail) p -= 2 * DB_UNIT;
            if (p < PRIO_FLOOR) p = PRIO_FLOOR;
            if (p > PRIO_CEIL) p = PRIO_CEIL;
            o.prio = PRIO_W'(p);

            full = grp_cnt[g] >= grp_limit[g];
            phys = (phys_limit < VOICES) ? phys_limit : VOICES;

            if (full || total >= phys) begin
                victim = -1;
                for (i = 0; i < VOICES; i++) begin
                    if (!used[i]) continue;
                    if (full ? (grp_of[i] != g) : (grp_cnt[grp_of[i]] <= resv)) continue;
                    if (victim < 0) begin
                        victim = i;
                    end else begin
                        span_i = age_now - age_of[i];
                        span_v = age_now - age_of[victim];
                        if (prio_of[i] < prio_of[victim] ||
                            (prio_of[i] == prio_of[victim] && span_i > span_v)) begin
                            victim = i;
                        end
                    end
                end
                if (victim < 0 || prio_of[victim] >= p) begin
                    o.status = ST_REFUSED;
                    n_refused++;
                    return o;
                end
                drop_voice(victim);
                o.evicted = 1'b1;
                o.ev_slot = SLOT_W'(victim);
                n_steal++;
            end

            free_slot = -1;
            for (i = VOICES - 1; i >= 0; i--) begin
                if (!used[i]) free_slot = i;
            end
            if (free_slot < 0) begin
                o = '{default: '0};
                o.status = ST_REFUSED;
                o.prio = PRIO_W'(p);
                n_refused++;
                return o;
            end
            used[free_slot] = 1'b1;
            grp_of[free_slot] = g;
            prio_of[free_slot] = p;
            age_of[free_slot] = age_now;
            age_now++;
            grp_cnt[g]++;
            total++;
            o.status = ST_DONE;
            o.slot = SLOT_W'(free_slot);
            return o;
        endfunction

        function void note_request(t_voice_req r);
            awaited_outcomes.insert(awaited_outcomes.size(), resolve_request(r));
        endfunction

        task report_mismatch(string msg);
            n_errors++;
            $display("[%0t] MISMATCH on result %0d: %s", $time, n_checked, msg);
        endtask

        task compare_field(string name, logic signed [31:0] got, logic signed [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
            end
        endtask

        task check_outcome(t_voice_outcome got);
            t_voice_outcome want;
            n_checked++;
            if (awaited_outcomes.size() == 0) begin
                report_mismatch("result word with no request pending");
                return;
            end
            want = awaited_outcomes.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("slot", 32'(got.slot), 32'(want.slot));
            compare_field("evicted", 32'(got.evicted), 32'(want.evicted));
            compare_field("evicted_slot", 32'(got.ev_slot), 32'(want.ev_slot));
            compare_field("priority", 32'(got.prio), 32'(want.prio));
        endtask
    endclass

endpackage

>>> sim/tb_top.sv
// Top-level testbench of the voice slot allocator: stimulus, result checking and watchdog.
`timescale 1ns / 1ps
module tb_top;
    import vsa_pkg::*;
    import voice_table_tb_pkg::*;

    localparam int IDLE_PCT     = 38;
    localparam int N_PHASES     = 7;
    localparam int PHASE_ITEMS  = 200;
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 850;
    localparam int N_HOLDS      = 2;
    localparam int HOLD_EVERY   = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 4;
    localparam int END_CYCLES   = 200;
    localparam int QUIET_LIMIT  = 3000;

    // weapons, vehicles, runtime, physical, reservation, allocate percent
    localparam int PHASE_CFG [N_PHASES][6] = '{
        '{48, 40, 48, 96, 12, 70},
        '{8, 8, 8, 128, 0, 70},
        '{128, 128, 128, 16, 4, 65},
        '{0, 128, 128, 128, 128, 70},
        '{128, 128, 128, 255, 0, 90},
        '{20, 20, 20, 1, 2, 60},
        '{60, 60, 60, 100, 30, 65}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [LIM_W-1:0]          i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic                      i_mode = 1'b0;
    logic [6:0]                i_release_slot = '0;
    logic                      i_is_runtime_effect = 1'b0;
    logic                      i_has_vehicle_source = 1'b0;
    logic signed [11:0]        i_mix_level = '0;
    logic signed [11:0]        i_output_gain = '0;
    logic                      i_front_end = 1'b0;
    logic                      i_looping = 1'b0;
    logic                      i_loop_pending = 1'b0;
    logic                      i_reports_completion = 1'b0;
    logic                      i_bullet_hit = 1'b0;
    logic                      i_tail = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [1:0]                o_status;
    logic [6:0]                o_slot;
    logic                      o_evicted;
    logic [6:0]                o_evicted_slot;
    logic signed [PRIO_W-1:0]  o_priority_res;

    voice_table_tracker sb;
    bit                 calm = 1'b0;
    int                 words_sent = 0;
    int                 results_seen = 0;

    voice_slot_allocator_with_stealing u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_mode               (i_mode),
        .i_release_slot       (i_release_slot),
        .i_is_runtime_effect  (i_is_runtime_effect),
        .i_has_vehicle_source (i_has_vehicle_source),
        .i_mix_level          (i_mix_level),
        .i_output_gain        (i_output_gain),
        .i_front_end          (i_front_end),
        .i_looping            (i_looping),
        .i_loop_pending       (i_loop_pending),
        .i_reports_completion (i_reports_completion),
        .i_bullet_hit         (i_bullet_hit),
        .i_tail               (i_tail),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_status             (o_status),
        .o_slot               (o_slot),
        .o_evicted            (o_evicted),
        .o_evicted_slot       (o_evicted_slot),
        .o_priority_res       (o_priority_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_voice_req alloc_word(t_grp g, int mix, int gain, bit [5:0] flags);
        t_voice_req w;
        w = '{default: '0};
        w.is_rt = (g == GRP_RT);
        w.has_veh = (g == GRP_VEH);
        w.mix = 12'(mix);
        w.gain = 12'(gain);
        {w.front_end, w.looping, w.loop_pending, w.reports, w.bullet, w.tail} = flags;
        return w;
    endfunction

    function automatic t_voice_req release_word(int s);
        t_voice_req w;
        w = '{default: '0};
        w.mode = 1'b1;
        w.rel_slot = SLOT_W'(s);
        return w;
    endfunction

    task automatic send_word(input t_voice_req w);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_mode = w.mode;
        i_release_slot = w.rel_slot;
        i_is_runtime_effect = w.is_rt;
        i_has_vehicle_source = w.has_veh;
        i_mix_level = w.mix;
        i_output_gain = w.gain;
        i_front_end = w.front_end;
        i_looping = w.looping;
        i_loop_pending = w.loop_pending;
        i_reports_completion = w.reports;
        i_bullet_hit = w.bullet;
        i_tail = w.tail;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_block();
        i_in_valid = 1'b0;
        while (sb.awaited_count() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_limit(input t_cfg_idx idx, input int value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value[LIM_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_limit(idx, value);
    endtask

    task automatic program_limits(input int wpn, input int veh, input int rt,
                                  input int phys, input int resv);
        write_limit(CFG_WPN_LIM, wpn);
        write_limit(CFG_VEH_LIM, veh);
        write_limit(CFG_RT_LIM, rt);
        write_limit(CFG_PHYS_LIM, phys);
        write_limit(CFG_RESV, resv);
    endtask

    initial begin : stimulus
        t_voice_req w;
        int         ph;
        int         k;
        int         pick;
        int         live;

        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(alloc_word(GRP_WPN, 1600, 1600, 6'b111100));
        send_word(alloc_word(GRP_RT, -1600, -1600, 6'b000011));
        send_word(alloc_word(GRP_VEH, 0, 0, 6'b001000));
        w = alloc_word(GRP_RT, 2047, 2047, 6'b100000);
        w.has_veh = 1'b1;
        send_word(w);
        send_word(alloc_word(GRP_WPN, -2048, -2048, 6'b000011));
        send_word(release_word(1));
        send_word(release_word(1));
        send_word(release_word(127));
        send_word(alloc_word(GRP_VEH, 0, 0, 6'b011000));
        send_word(alloc_word(GRP_WPN, 0, 0, 6'b000100));

        drain_block();
        program_limits(2, 2, 2, 5, 0);
        send_word(alloc_word(GRP_WPN, 0, 0, 6'b000000));
        send_word(alloc_word(GRP_VEH, 0, 0, 6'b010000));
        send_word(alloc_word(GRP_VEH, 16, 0, 6'b010000));
        send_word(alloc_word(GRP_RT, 32, 0, 6'b000000));
        send_word(alloc_word(GRP_RT, -1600, -1600, 6'b000011));
        send_word(release_word(0));
        send_word(release_word(3));
        send_word(alloc_word(GRP_RT, 1600, 0, 6'b000000));

        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_block();
            program_limits(PHASE_CFG[ph][0], PHASE_CFG[ph][1], PHASE_CFG[ph][2],
                           PHASE_CFG[ph][3], PHASE_CFG[ph][4]);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                w.mode = ($urandom_range(99) >= PHASE_CFG[ph][5]);
                w.rel_slot = SLOT_W'($urandom_range(127));
                w.is_rt = 1'($urandom_range(1));
                w.has_veh = 1'($urandom_range(1));
                pick = $urandom_range(99);
                if (pick < 25) begin
                    w.mix = 12'(16 * $urandom_range(3));
                    w.gain = '0;
                end else if (pick < 30) begin
                    w.mix = 12'($urandom_range(1) ? 1600 : -1600);
                    w.gain = 12'($urandom_range(1) ? 1600 : -1600);
                end else begin
                    w.mix = 12'(int'($urandom_range(3200)) - 1600);
                    w.gain = 12'(int'($urandom_range(3200)) - 1600);
                end
                {w.front_end, w.looping, w.loop_pending, w.reports, w.bullet, w.tail} =
                    6'($urandom_range(63));
                if (w.mode && $urandom_range(99) < 85) begin
                    live = sb.pick_live_slot();
                    if (live >= 0) w.rel_slot = SLOT_W'(live);
                end
                calm = (words_sent >= CALM_FROM && words_sent < CALM_TO);
                send_word(w);
            end
        end
        calm = 1'b0;

        drain_block();
        repeat (END_CYCLES) @(negedge i_clk);
        $display("Run covered %0d requests: %0d allocations (%0d stole a voice, %0d refused)",
                 words_sent, sb.n_alloc, sb.n_steal, sb.n_refused);
        $display("and %0d releases (%0d of empty slots) across %0d limit settings.",
                 sb.n_release, sb.n_empty, N_PHASES + 2);
        if (sb.n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : result_side
        t_voice_outcome got;
        int             holds;
        int             hold_k;

        holds = 0;
        forever begin
            @(negedge i_clk);
            if (holds < N_HOLDS && results_seen >= HOLD_EVERY * (holds + 1)) begin
                i_out_ready = 1'b0;
                holds++;
                for (hold_k = 0; hold_k < HOLD_CYCLES; hold_k++) @(negedge i_clk);
            end
            i_out_ready = calm || ($urandom_range(99) >= IDLE_PCT);
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.status = o_status;
                got.slot = o_slot;
                got.evicted = o_evicted;
                got.ev_slot = o_evicted_slot;
                got.prio = o_priority_res;
                sb.check_outcome(got);
                results_seen++;
            end
        end
    end

    initial begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/vsa_pkg.sv
sv/vsa_prio.sv
sv/vsa_table.sv
sv/vsa_scan.sv
sv/voice_slot_allocator_with_stealing.sv
sim/voice_table_tb_pkg.sv
sim/tb_top.sv
